// File: rtl/core/mlfs_pkg.sv
// Shared constants and types for the multilevel feedback scheduler.
package mlfs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_LEVELS  = 4;
    localparam int LVL_W       = 2;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = LVL_W + IDX_W;
    localparam int RAM_DEPTH   = NUM_LEVELS << IDX_W;
    localparam int ID_W        = 4;
    localparam int LEVEL_W     = 3;
    localparam int SLOT_W      = 4;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_ADMIT = 1'b1;

    localparam logic [LVL_W-1:0] BOTTOM_LVL = LVL_W'(NUM_LEVELS - 1);

    typedef enum logic [2:0] {
        OUT_IDLE    = 3'd0,
        OUT_CONT    = 3'd1,
        OUT_FIN     = 3'd2,
        OUT_BLK     = 3'd3,
        OUT_PREEMPT = 3'd4
    } outcome_t;

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [LEVEL_W-1:0] level_t;

endpackage

// File: rtl/core/mlfs_in_if.sv
// Input channel: tick and admit items.
interface mlfs_in_if;
    logic                  valid;
    logic                  ready;
    logic                  func;
    mlfs_pkg::id_t         task_id;
    mlfs_pkg::level_t      admit_level;
    logic                  task_finished;
    logic                  task_blocked;

    modport source (output valid, func, task_id, admit_level, task_finished, task_blocked,
                    input ready);
    modport sink   (input valid, func, task_id, admit_level, task_finished, task_blocked,
                    output ready);
endinterface

// File: rtl/core/mlfs_out_if.sv
// Output channel: one scheduling result per input item.
interface mlfs_out_if;
    logic                  valid;
    logic                  ready;
    logic                  ran_valid;
    mlfs_pkg::id_t         ran_id;
    mlfs_pkg::level_t      new_level;
    mlfs_pkg::outcome_t    outcome;
    logic                  dropped;

    modport source (output valid, ran_valid, ran_id, new_level, outcome, dropped,
                    input ready);
    modport sink   (input valid, ran_valid, ran_id, new_level, outcome, dropped,
                    output ready);
endinterface

// File: rtl/core/multilevel_feedback_scheduler_core.sv
// Four-level feedback scheduler: level FIFOs in RAM, driven by a small sequencer.
//
// Channels: task_in carries one item per transfer (func 0 tick, 1 admit);
// result returns exactly one item per accepted input, in order.
// Admit appends task_id to the FIFO of admit_level; a full FIFO flags dropped.
// Tick picks the head of the highest non-empty level when nothing runs,
// charges the running task one slot and reports continue, finish, block or
// preempt; a preempted task is queued again one level lower (at level 4, again at level 4).
// Path from input transfer to result: an idle tick or an ignored admit
// goes straight to S_OUT; an admit passes S_PUSH, a tick with a task already
// running S_CHARGE, a preempting tick S_CHARGE and S_PUSH; a pick first reads
// the FIFO head in S_RD and S_CHK, as the FIFO RAM read port is registered.
// A level-4 pick that meets the last level-4 task rotates that entry to the
// tail and reads again, at most once per queued entry. One item is in work at
// a time: task_in.ready is high only while idle, so a new item is accepted only after the last result is taken.
// Reset empties all FIFOs (heads and counts cleared), clears the running
// task and the level-4 history. While the receiver holds result.ready low,
// the result holds and no new item is accepted.
module multilevel_feedback_scheduler_core (
    input  logic       clk,
    input  logic       rst_n,
    mlfs_in_if.sink    task_in,
    mlfs_out_if.source result
);
    import mlfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_CHARGE,
        S_PUSH,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic                 fin_reg, fin_next;
    logic                 blk_reg, blk_next;
    logic [CNT_W-1:0]     rot_reg, rot_next;
    id_t                  push_id_reg, push_id_next;
    logic [IDX_W-1:0]     heads_reg [NUM_LEVELS];
    logic [IDX_W-1:0]     heads_next [NUM_LEVELS];
    logic [CNT_W-1:0]     counts_reg [NUM_LEVELS];
    logic [CNT_W-1:0]     counts_next [NUM_LEVELS];
    logic                 run_valid_reg, run_valid_next;
    id_t                  run_id_reg, run_id_next;
    level_t               run_level_reg, run_level_next;
    logic [SLOT_W-1:0]    slots_reg, slots_next;
    logic                 lb_valid_reg, lb_valid_next;
    id_t                  lb_id_reg, lb_id_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 ran_valid_reg, ran_valid_next;
    id_t                  ran_id_reg, ran_id_next;
    level_t               new_level_reg, new_level_next;
    outcome_t             outcome_reg, outcome_next;
    logic                 dropped_reg, dropped_next;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    id_t                  ram_wr_data;
    logic [ADDR_W-1:0]    ram_rd_addr;
    id_t                  ram_rd_data;

    logic [IDX_W-1:0]     cur_head;
    logic [CNT_W-1:0]     cur_count;
    logic [CNT_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [IDX_W-1:0]     head_inc;
    logic                 any_queued;
    logic [LVL_W-1:0]     pick_lvl;
    logic                 take;
    level_t               lv_c;
    level_t               lv_down;
    logic [SLOT_W-1:0]    slot_inc;
    logic [SLOT_W-1:0]    quantum;

    mlfs_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cur_head   = heads_reg[lvl_reg];
    assign cur_count  = counts_reg[lvl_reg];
    assign tail_sum   = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_count);
    assign tail_idx   = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                      : IDX_W'(tail_sum);
    assign head_inc   = (cur_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign ram_rd_addr = {lvl_reg, cur_head};
    assign ram_wr_addr = {lvl_reg, tail_idx};

    always_comb
    begin
        any_queued = 1'b0;
        pick_lvl   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (counts_reg[i] != '0)
            begin
                any_queued = 1'b1;
                pick_lvl   = LVL_W'(i);
            end
        end
    end

    assign take = (lvl_reg != BOTTOM_LVL) || !lb_valid_reg || (ram_rd_data != lb_id_reg)
                  || (rot_reg == cur_count);

    assign lv_c     = (run_level_reg == '0) ? level_t'(1)
                    : (run_level_reg > level_t'(NUM_LEVELS)) ? level_t'(NUM_LEVELS)
                    : run_level_reg;
    assign lv_down  = (lv_c < level_t'(NUM_LEVELS)) ? lv_c + 1'b1 : lv_c;
    assign slot_inc = slots_reg + 1'b1;
    assign quantum  = SLOT_W'(1) << (lv_c - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        fin_next       = fin_reg;
        blk_next       = blk_reg;
        rot_next       = rot_reg;
        push_id_next   = push_id_reg;
        heads_next     = heads_reg;
        counts_next    = counts_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_level_next = run_level_reg;
        slots_next     = slots_reg;
        lb_valid_next  = lb_valid_reg;
        lb_id_next     = lb_id_reg;
        out_valid_next = out_valid_reg;
        ran_valid_next = ran_valid_reg;
        ran_id_next    = ran_id_reg;
        new_level_next = new_level_reg;
        outcome_next   = outcome_reg;
        dropped_next   = dropped_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = push_id_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (task_in.valid)
                begin
                    fin_next       = task_in.task_finished;
                    blk_next       = task_in.task_blocked;
                    push_id_next   = task_in.task_id;
                    rot_next       = '0;
                    ran_valid_next = 1'b0;
                    ran_id_next    = '0;
                    new_level_next = '0;
                    outcome_next   = OUT_IDLE;
                    dropped_next   = 1'b0;
                    if (task_in.func == FUNC_ADMIT)
                    begin
                        if (task_in.admit_level >= level_t'(1)
                            && task_in.admit_level <= level_t'(NUM_LEVELS))
                        begin
                            lvl_next   = LVL_W'(task_in.admit_level - 1'b1);
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                    end
                    else if (run_valid_reg)
                    begin
                        state_next = S_CHARGE;
                    end
                    else if (any_queued)
                    begin
                        lvl_next   = pick_lvl;
                        state_next = S_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_CHK;
            end

            S_CHK:
            begin
                heads_next[lvl_reg] = head_inc;
                if (take)
                begin
                    counts_next[lvl_reg] = cur_count - 1'b1;
                    run_valid_next       = 1'b1;
                    run_id_next          = ram_rd_data;
                    run_level_next       = {1'b0, lvl_reg} + 1'b1;
                    slots_next           = '0;
                    if (lvl_reg == BOTTOM_LVL)
                    begin
                        lb_valid_next = 1'b1;
                        lb_id_next    = ram_rd_data;
                    end
                    state_next = S_CHARGE;
                end
                else
                begin
                    // same id as last bottom-level pick: rotate head to tail
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    rot_next    = rot_reg + 1'b1;
                    state_next  = S_RD;
                end
            end

            S_CHARGE:
            begin
                ran_valid_next = 1'b1;
                ran_id_next    = run_id_reg;
                slots_next     = slot_inc;
                if (fin_reg)
                begin
                    new_level_next = lv_c;
                    outcome_next   = OUT_FIN;
                    run_valid_next = 1'b0;
                    slots_next     = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (blk_reg)
                begin
                    new_level_next = lv_down;
                    outcome_next   = OUT_BLK;
                    run_valid_next = 1'b0;
                    slots_next     = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (slot_inc >= quantum)
                begin
                    new_level_next = lv_down;
                    run_level_next = lv_down;
                    outcome_next   = OUT_PREEMPT;
                    run_valid_next = 1'b0;
                    slots_next     = '0;
                    lvl_next       = LVL_W'(lv_down - 1'b1);
                    push_id_next   = run_id_reg;
                    state_next     = S_PUSH;
                end
                else
                begin
                    new_level_next = lv_c;
                    outcome_next   = OUT_CONT;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end

            S_PUSH:
            begin
                if (cur_count < CNT_W'(QUEUE_DEPTH))
                begin
                    ram_wr_en            = 1'b1;
                    counts_next[lvl_reg] = cur_count + 1'b1;
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end

            S_OUT:
            begin
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            fin_reg       <= 1'b0;
            blk_reg       <= 1'b0;
            rot_reg       <= '0;
            push_id_reg   <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_level_reg <= level_t'(1);
            slots_reg     <= '0;
            lb_valid_reg  <= 1'b0;
            lb_id_reg     <= '0;
            out_valid_reg <= 1'b0;
            ran_valid_reg <= 1'b0;
            ran_id_reg    <= '0;
            new_level_reg <= '0;
            outcome_reg   <= OUT_IDLE;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            fin_reg       <= fin_next;
            blk_reg       <= blk_next;
            rot_reg       <= rot_next;
            push_id_reg   <= push_id_next;
            heads_reg     <= heads_next;
            counts_reg    <= counts_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_level_reg <= run_level_next;
            slots_reg     <= slots_next;
            lb_valid_reg  <= lb_valid_next;
            lb_id_reg     <= lb_id_next;
            out_valid_reg <= out_valid_next;
            ran_valid_reg <= ran_valid_next;
            ran_id_reg    <= ran_id_next;
            new_level_reg <= new_level_next;
            outcome_reg   <= outcome_next;
            dropped_reg   <= dropped_next;
        end
    end

    assign task_in.ready    = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.ran_valid = ran_valid_reg;
    assign result.ran_id    = ran_id_reg;
    assign result.new_level = new_level_reg;
    assign result.outcome   = outcome_reg;
    assign result.dropped   = dropped_reg;

endmodule

// File: rtl/core/mlfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mlfs_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
module mlfs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               ran_valid,
    input mlfs_pkg::id_t      ran_id,
    input mlfs_pkg::level_t   new_level,
    input mlfs_pkg::outcome_t outcome,
    input logic               dropped
);
    import mlfs_pkg::*;

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in work");

    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("ready for input while a result is pending");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ran_valid) && $stable(ran_id)
            && $stable(new_level) && $stable(outcome) && $stable(dropped))
        else $error("stalled result changed");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ran_valid |-> ran_id == '0 && new_level == '0 && outcome == OUT_IDLE)
        else $error("result fields set without a task run");

    a_ran_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ran_valid |-> (new_level >= level_t'(1))
            && (new_level <= level_t'(NUM_LEVELS))
            && (outcome == OUT_CONT || outcome == OUT_FIN || outcome == OUT_BLK
                || outcome == OUT_PREEMPT)
            && (!dropped || outcome == OUT_PREEMPT))
        else $error("inconsistent result for a task run");

endmodule

bind multilevel_feedback_scheduler_core mlfs_checker u_mlfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (task_in.valid),
    .in_ready  (task_in.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ran_valid (result.ran_valid),
    .ran_id    (result.ran_id),
    .new_level (result.new_level),
    .outcome   (result.outcome),
    .dropped   (result.dropped)
);
